// ===== hw/rtl/twht_pkg.sv =====
// ----------------------------------------------------------------------------
// twht_pkg: shared types and constants
// Entry layout, request codes and controller states for the two-way table.
// ----------------------------------------------------------------------------
package twht_pkg;

   localparam int KeyBits   = 64;
   localparam int DepthBits = 7;
   localparam int ScoreBits = 16;
   localparam int MoveBits  = 32;
   localparam int BoundBits = 2;
   localparam int CfgBits   = 5;
   localparam int EntryBits = KeyBits + DepthBits + ScoreBits + MoveBits + BoundBits;

   // smallest usable index width
   localparam logic [CfgBits-1:0] MinIndexBits = 5'd10;
   // index width after reset
   localparam logic [CfgBits-1:0] ResetIndexBits = 5'd16;

   localparam logic CmdProbe = 1'b0;
   localparam logic CmdStore = 1'b1;

   typedef struct packed {
      logic [KeyBits-1:0]          key;
      logic [DepthBits-1:0]        depth;
      logic signed [ScoreBits-1:0] score;
      logic [MoveBits-1:0]         move;
      logic [BoundBits-1:0]        bound;
   } entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

// ===== hw/rtl/two_way_depth_preferred_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// two_way_depth_preferred_hash_table_core: two-way hashed entry table
// Buckets of a depth-preferred way and an always-replace way, probed and
// updated by 64-bit key.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): req_cmd selects probe or store. A request is
//   taken on a clock edge with req_valid high and req_stall low.
//   Response channel (rsp_*): one response per probe, none per store.
//   Taken on an edge with rsp_valid high and rsp_stall low.
//   csr_we/csr_wdata set the index width (low key bits selecting the
//   bucket, clamped to 10..MAX_INDEX_BITS). Write only while idle.
// Timing:
//   A request is handled in order: bucket read on the accept edge, then the
//   compare/write-back cycle on the single read and write port of each way.
//   No new request is taken until the lookup ends. A probe response is
//   registered at the end of lookup, once the response register is free.
//   A response waiting on rsp_stall does not block further requests; only a
//   second probe finding the response register still full waits in lookup.
// Reset:
//   Synchronous, active high. After reset both ways are swept to zero, one
//   bucket per cycle over all 2**MAX_INDEX_BITS buckets, req_stall held high.
//   Key zero then matches empty entries.
// ----------------------------------------------------------------------------
module two_way_depth_preferred_hash_table_core
   import twht_pkg::*;
#(
   parameter int MAX_INDEX_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_cmd,
   input  logic [KeyBits-1:0]          req_key,
   input  logic [DepthBits-1:0]        req_depth,
   input  logic signed [ScoreBits-1:0] req_score,
   input  logic [MoveBits-1:0]         req_move_code,
   input  logic [BoundBits-1:0]        req_bound,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_hit,
   output logic                        rsp_hit_way,
   output logic [DepthBits-1:0]        rsp_out_depth,
   output logic signed [ScoreBits-1:0] rsp_out_score,
   output logic [MoveBits-1:0]         rsp_out_move,
   output logic [BoundBits-1:0]        rsp_out_bound,
   // configuration
   input  logic                        csr_we,
   input  logic [CfgBits-1:0]          csr_wdata
);

   localparam int AddrBits = MAX_INDEX_BITS;
   localparam logic [CfgBits-1:0] MaxBits = CfgBits'(MAX_INDEX_BITS);

   // ---------------------------------------------------------------- state
   state_type state_ff, state_in;

   logic [CfgBits-1:0]  index_bits_ff, index_bits_in;
   logic [AddrBits-1:0] clr_addr_ff, clr_addr_in;

   // captured request
   logic                        cmd_ff;
   entry_type                   req_ff;
   logic [AddrBits-1:0]         bucket_ff;

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_hit_ff, rsp_hit_way_ff;
   entry_type                   rsp_entry_ff;

   // --------------------------------------------------------- bucket index
   logic [CfgBits-1:0]  eff_bits;
   logic [AddrBits-1:0] bucket_mask;
   logic [AddrBits-1:0] bucket;

   always_comb begin
      if (index_bits_ff < MinIndexBits) begin
         eff_bits = MinIndexBits;
      end else if (index_bits_ff > MaxBits) begin
         eff_bits = MaxBits;
      end else begin
         eff_bits = index_bits_ff;
      end
      for (int i = 0; i < AddrBits; i++) begin
         bucket_mask[i] = (CfgBits'(i) < eff_bits);
      end
      bucket = req_key[AddrBits-1:0] & bucket_mask;
   end

   // --------------------------------------------------------------- memories
   logic                rd_en;
   logic                wr0_en, wr1_en;
   logic [AddrBits-1:0] wr_addr;
   entry_type           wr_data;
   entry_type           way0, way1;

   twht_mem #(.ADDR_BITS(AddrBits)) u_way0 (
      .clock   (clock),
      .wr_en   (wr0_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (bucket),
      .rd_data (way0)
   );

   twht_mem #(.ADDR_BITS(AddrBits)) u_way1 (
      .clock   (clock),
      .wr_en   (wr1_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (bucket),
      .rd_data (way1)
   );

   // ------------------------------------------------------- bucket decisions
   logic hit0, hit1;
   logic keep_deep;   // new entry goes to the depth-preferred way
   logic rsp_free;
   logic accept;
   logic rsp_load;

   assign hit0      = (way0.key == req_ff.key);
   assign hit1      = (way1.key == req_ff.key);
   assign keep_deep = hit0 || (req_ff.depth >= way0.depth);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // --------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (&clr_addr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (cmd_ff == CmdStore || rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // ------------------------------------------------------------- outputs
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      wr0_en    = 1'b0;
      wr1_en    = 1'b0;
      wr_addr   = bucket_ff;
      wr_data   = req_ff;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr0_en  = 1'b1;
            wr1_en  = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = '0;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            rd_en     = req_valid;
         end
         ST_LOOKUP: begin
            if (cmd_ff == CmdStore) begin
               wr0_en = keep_deep;
               wr1_en = !keep_deep;
               // a moveless store onto the same key in way 0 keeps the old move
               if (hit0 && req_ff.move == '0) begin
                  wr_data.move = way0.move;
               end
            end else begin
               rsp_load = rsp_free;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   // ------------------------------------------------------ control registers
   always_comb begin
      index_bits_in = csr_we ? csr_wdata : index_bits_ff;
      clr_addr_in   = (state_ff == ST_CLEAR) ? clr_addr_ff + AddrBits'(1) : clr_addr_ff;
      rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         index_bits_ff <= ResetIndexBits;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         index_bits_ff <= index_bits_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------ payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff       <= req_cmd;
         bucket_ff    <= bucket;
         req_ff.key   <= req_key;
         req_ff.depth <= req_depth;
         req_ff.score <= req_score;
         req_ff.move  <= req_move_code;
         req_ff.bound <= req_bound;
      end
   end

   // way 0 wins when both match; a miss returns all zeros
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_hit_ff     <= hit0 || hit1;
         rsp_hit_way_ff <= !hit0 && hit1;
         if (hit0) begin
            rsp_entry_ff <= way0;
         end else if (hit1) begin
            rsp_entry_ff <= way1;
         end else begin
            rsp_entry_ff <= '0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_hit_way   = rsp_hit_way_ff;
   assign rsp_out_depth = rsp_entry_ff.depth;
   assign rsp_out_score = rsp_entry_ff.score;
   assign rsp_out_move  = rsp_entry_ff.move;
   assign rsp_out_bound = rsp_entry_ff.bound;

endmodule

// ===== hw/rtl/twht_mem.sv =====
// ----------------------------------------------------------------------------
// twht_mem: one way of the bucket store
// Synchronous single-write, single-read memory; read data registered and
// held until the next read.
// ----------------------------------------------------------------------------
module twht_mem
   import twht_pkg::*;
#(
   parameter int ADDR_BITS = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  entry_type            wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output entry_type            rd_data
);

   localparam int Depth = 1 << ADDR_BITS;

   entry_type mem [Depth];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
